// ----- rtl/bc1_pkg.sv -----
// shared types, constants and colour arithmetic for the bc1 block decoder
package bc1_pkg;

   localparam int unsigned MaxBlocksAcross = 1024;
   localparam int unsigned HeightLimit     = 1024;
   localparam int unsigned CsrDataWidth    = 11;
   localparam int unsigned CoordWidth      = 10;

   typedef enum logic {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
   } color_type;

   typedef struct packed {
      color_type [3:0]         palette;
      logic [31:0]             indices;
      logic [CoordWidth-1:0]   column;
      logic [CoordWidth-1:0]   row;
      logic                    last_image;
   } block_entry_type;

   // x*255/31 = 8x + floor(7x/31)
   function automatic logic [7:0] expand5(input logic [4:0] x);
      logic [7:0] t;
      logic [2:0] f;
      t = {x, 3'b000} - {3'b000, x};
      f = 3'(t >= 8'd31) + 3'(t >= 8'd62) + 3'(t >= 8'd93)
        + 3'(t >= 8'd124) + 3'(t >= 8'd155) + 3'(t >= 8'd186)
        + 3'(t >= 8'd217);
      return {x, 3'b000} + {5'b00000, f};
   endfunction

   // x*255/63 = 4x + floor(x/21)
   function automatic logic [7:0] expand6(input logic [5:0] x);
      logic [1:0] f;
      f = 2'(x >= 6'd21) + 2'(x >= 6'd42) + 2'(x >= 6'd63);
      return {x, 2'b00} + {6'b000000, f};
   endfunction

   // floor((2a+b)/3) via reciprocal 683/2048, exact below 2048
   function automatic logic [7:0] mix_third(input logic [7:0] a, input logic [7:0] b);
      logic [9:0]  s;
      logic [19:0] p;
      s = {1'b0, a, 1'b0} + {2'b00, b};
      p = 20'(s) * 20'd683;
      return p[18:11];
   endfunction

   function automatic logic [7:0] mix_half(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8:1];
   endfunction

endpackage

// ----- rtl/bc1_front.sv -----
// front end: config registers, block position counter and palette build
module bc1_front import bc1_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic                    csr_index,
   input  logic [CsrDataWidth-1:0] csr_data,
   input  logic                    req_push,
   input  logic [63:0]             req_block_word,
   output logic                    req_full,
   output logic                    q_push,
   output block_entry_type         q_entry,
   input  logic                    q_full
);

   logic [CsrDataWidth-1:0] width_ff, width_in;
   logic [CsrDataWidth-1:0] height_ff, height_in;
   logic [CoordWidth-1:0]   col_ff, col_in;
   logic [CoordWidth-1:0]   row_ff, row_in;
   logic                    s1_valid_ff, s1_valid_in;
   logic [63:0]             s1_word_ff;
   logic [CoordWidth-1:0]   s1_col_ff;
   logic [CoordWidth-1:0]   s1_row_ff;
   logic                    s1_last_ff;

   logic                    accept;
   logic [CsrDataWidth-1:0] wb, hb;
   logic [CsrDataWidth-1:0] col_inc, row_inc;
   logic                    end_row, end_img;
   logic [15:0]             c0, c1;
   color_type               e0, e1, e2, e3;

   assign accept   = req_push && !req_full;
   assign req_full = s1_valid_ff && q_full;
   assign q_push   = s1_valid_ff && !q_full;

   // register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_WIDTH:  width_in  = csr_data;
            CSR_HEIGHT: height_in = csr_data;
            default:    width_in  = width_ff;
         endcase
      end
   end

   // position walk, zero acts as one and oversize clamps
   always_comb begin
      wb = (width_ff == '0) ? CsrDataWidth'(1) :
           (width_ff > CsrDataWidth'(MaxBlocksAcross)) ? CsrDataWidth'(MaxBlocksAcross) :
           width_ff;
      hb = (height_ff == '0) ? CsrDataWidth'(1) :
           (height_ff > CsrDataWidth'(HeightLimit)) ? CsrDataWidth'(HeightLimit) :
           height_ff;
      col_inc = {1'b0, col_ff} + CsrDataWidth'(1);
      row_inc = {1'b0, row_ff} + CsrDataWidth'(1);
      end_row = col_inc >= wb;
      end_img = end_row && (row_inc >= hb);
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (end_row) begin
            col_in = '0;
            row_in = end_img ? '0 : row_inc[CoordWidth-1:0];
         end else begin
            col_in = col_inc[CoordWidth-1:0];
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (q_push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= CsrDataWidth'(128);
         height_ff   <= CsrDataWidth'(128);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff <= req_block_word;
         s1_col_ff  <= col_ff;
         s1_row_ff  <= row_ff;
         s1_last_ff <= end_img;
      end
   end

   // endpoint expansion and palette
   always_comb begin
      c0 = s1_word_ff[15:0];
      c1 = s1_word_ff[31:16];
      e0.red   = expand5(c0[15:11]);
      e0.green = expand6(c0[10:5]);
      e0.blue  = expand5(c0[4:0]);
      e0.alpha = 8'hFF;
      e1.red   = expand5(c1[15:11]);
      e1.green = expand6(c1[10:5]);
      e1.blue  = expand5(c1[4:0]);
      e1.alpha = 8'hFF;
      if (c0 > c1) begin
         e2.red   = mix_third(e0.red, e1.red);
         e2.green = mix_third(e0.green, e1.green);
         e2.blue  = mix_third(e0.blue, e1.blue);
         e2.alpha = 8'hFF;
         e3.red   = mix_third(e1.red, e0.red);
         e3.green = mix_third(e1.green, e0.green);
         e3.blue  = mix_third(e1.blue, e0.blue);
         e3.alpha = 8'hFF;
      end else begin
         e2.red   = mix_half(e0.red, e1.red);
         e2.green = mix_half(e0.green, e1.green);
         e2.blue  = mix_half(e0.blue, e1.blue);
         e2.alpha = 8'hFF;
         // transparent black
         e3       = '0;
      end
      q_entry.palette    = {e3, e2, e1, e0};
      q_entry.indices    = s1_word_ff[63:32];
      q_entry.column     = s1_col_ff;
      q_entry.row        = s1_row_ff;
      q_entry.last_image = s1_last_ff;
   end

endmodule

// ----- rtl/bc1_queue.sv -----
// two-entry block queue between the front end and the pixel sequencer
module bc1_queue import bc1_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  block_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output block_entry_type head,
   output logic            empty
);

   block_entry_type mem [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = count_ff == 2'd2;
   assign empty   = count_ff == 2'd0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ff];

   always_comb begin
      wr_in    = do_push ? ~wr_ff : wr_ff;
      rd_in    = do_pop ? ~rd_ff : rd_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/bc1_back.sv -----
// pixel sequencer: walks the sixteen pixels of the head block into the result register
module bc1_back import bc1_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  block_entry_type head,
   input  logic            q_empty,
   output logic            q_pop,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output logic [11:0]     rsp_pixel_x,
   output logic [11:0]     rsp_pixel_y,
   output logic [7:0]      rsp_blue,
   output logic [7:0]      rsp_green,
   output logic [7:0]      rsp_red,
   output logic [7:0]      rsp_alpha,
   output logic            rsp_last_of_block,
   output logic            rsp_last_of_image
);

   logic [3:0]  pix_ff, pix_in;
   logic        valid_ff, valid_in;
   logic        step;
   logic [1:0]  k;
   color_type   col;
   logic        last;

   assign rsp_empty = !valid_ff;
   assign step      = !q_empty && (!valid_ff || rsp_pop);
   assign last      = pix_ff == 4'hF;
   assign q_pop     = step && last;
   assign k         = head.indices[{pix_ff, 1'b0} +: 2];
   assign col       = head.palette[k];

   always_comb begin
      pix_in   = step ? pix_ff + 4'd1 : pix_ff;
      valid_in = valid_ff;
      if (step) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pix_ff   <= pix_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_pixel_x       <= {head.column, pix_ff[1:0]};
         rsp_pixel_y       <= {head.row, pix_ff[3:2]};
         rsp_blue          <= col.blue;
         rsp_green         <= col.green;
         rsp_red           <= col.red;
         rsp_alpha         <= col.alpha;
         rsp_last_of_block <= last;
         rsp_last_of_image <= last && head.last_image;
      end
   end

endmodule

// ----- rtl/bc1_block_decoder.sv -----
// top level of the bc1 texture block decoder
//
// Input queue side: drive req_block_word and raise req_push; the 64-bit block
// (colour0 in bits 15:0, colour1 in 31:16, sixteen 2-bit indices above) is
// taken on any edge where req_full is low. Blocks arrive in raster block order.
// Result queue side: while rsp_empty is low the oldest pixel sits on the rsp_
// ports; pulse rsp_pop to take it. Each block gives sixteen pixels in row-major
// order, rsp_last_of_block flags the sixteenth, rsp_last_of_image the final
// pixel of the final block of the image.
// csr_write with csr_index 0 sets the width in blocks, index 1 the height;
// write only while idle. Reset sets both to 128 and the block position to 0,0.
// A block is registered in the input stage, then in the block queue, and its
// pixels leave through the result register. Throughput: one pixel per cycle
// while rsp_pop keeps up, set by the single result register fed by the pixel
// sequencer. A two-entry block queue and an input stage let two further blocks
// be taken while a block drains. When the receiver stops popping, the result
// register holds, the queue fills and req_full rises; nothing is lost.
module bc1_block_decoder import bc1_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic                    csr_index,
   input  logic [CsrDataWidth-1:0] csr_data,
   input  logic                    req_push,
   input  logic [63:0]             req_block_word,
   output logic                    req_full,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [11:0]             rsp_pixel_x,
   output logic [11:0]             rsp_pixel_y,
   output logic [7:0]              rsp_blue,
   output logic [7:0]              rsp_green,
   output logic [7:0]              rsp_red,
   output logic [7:0]              rsp_alpha,
   output logic                    rsp_last_of_block,
   output logic                    rsp_last_of_image
);

   logic            q_push, q_full, q_pop, q_empty;
   block_entry_type q_entry, q_head;

   bc1_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_push       (req_push),
      .req_block_word (req_block_word),
      .req_full       (req_full),
      .q_push         (q_push),
      .q_entry        (q_entry),
      .q_full         (q_full)
   );

   bc1_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   bc1_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (q_head),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_blue          (rsp_blue),
      .rsp_green         (rsp_green),
      .rsp_red           (rsp_red),
      .rsp_alpha         (rsp_alpha),
      .rsp_last_of_block (rsp_last_of_block),
      .rsp_last_of_image (rsp_last_of_image)
   );

endmodule

// ----- rtl/bc1_checker.sv -----
// port-level checks for the bc1 block decoder, bound to the top level
module bc1_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [11:0] rsp_pixel_x,
   input logic [11:0] rsp_pixel_y,
   input logic [7:0]  rsp_blue,
   input logic        rsp_last_of_block,
   input logic        rsp_last_of_image
);

   // nothing pending straight after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("bc1: queues not empty after reset");

   // a stalled result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_pixel_x)
         && $stable(rsp_pixel_y) && $stable(rsp_blue))
      else $error("bc1: stalled result changed");

   // image end only on a block end
   a_image_end: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_last_of_image |-> rsp_last_of_block)
      else $error("bc1: last_of_image without last_of_block");

   // block end is the bottom-right pixel of its block
   a_block_corner: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_last_of_block |->
         rsp_pixel_x[1:0] == 2'd3 && rsp_pixel_y[1:0] == 2'd3)
      else $error("bc1: last_of_block off the block corner");

   // a pixel after a block end starts a new block at its top-left
   a_block_start: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && rsp_last_of_block ##1 !rsp_empty |->
         rsp_pixel_x[1:0] == 2'd0 && rsp_pixel_y[1:0] == 2'd0)
      else $error("bc1: block did not start at its top-left pixel");

endmodule

bind bc1_block_decoder bc1_checker u_bc1_checker (
   .clock             (clock),
   .reset             (reset),
   .req_full          (req_full),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_pixel_x       (rsp_pixel_x),
   .rsp_pixel_y       (rsp_pixel_y),
   .rsp_blue          (rsp_blue),
   .rsp_last_of_block (rsp_last_of_block),
   .rsp_last_of_image (rsp_last_of_image)
);
